### hw/rtl/sact_pkg.sv
// ----------------------------------------------------------------------------
// sact_pkg: shared types and constants of the cache tag controller
// Geometry, policy codes and the row layout of the set memory.
// ----------------------------------------------------------------------------
package sact_pkg;

    localparam int WAYS        = 4;
    localparam int SETS        = 64;
    localparam int ADDR_BITS   = 32;
    localparam int OFFSET_BITS = 6;
    localparam int LINE_BITS   = ADDR_BITS - OFFSET_BITS;
    localparam int SET_BITS    = $clog2(SETS);
    localparam int WAY_BITS    = $clog2(WAYS);
    localparam int AGE_BITS    = 8;
    localparam int TREE_BITS   = WAYS - 1;

    localparam logic [1:0] POL_FIFO = 2'd0;
    localparam logic [1:0] POL_BITP = 2'd1;
    localparam logic [1:0] POL_TREE = 2'd2;
    localparam logic [1:0] POL_AGE  = 2'd3;
    localparam logic [1:0] POL_RESET = POL_TREE;

    typedef struct packed {
        logic [WAYS-1:0][LINE_BITS-1:0] tag;
        logic [WAYS-1:0]                valid;
        logic [WAYS-1:0]                dirty;
        logic [WAYS-1:0]                mark;
        logic [WAYS-1:0][AGE_BITS-1:0]  age;
        logic [WAY_BITS-1:0]            fifo;
        logic [TREE_BITS-1:0]           tree;
    } row_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } ctl_cmd_t;

    typedef struct packed {
        logic out_blocked;
    } ctl_status_t;

endpackage

### hw/rtl/sact_controller.sv
// ----------------------------------------------------------------------------
// sact_controller: sequencing of one access
// Takes an item, waits for the set read, then commits the update once the output is not blocked.
// ----------------------------------------------------------------------------
module sact_controller
    import sact_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  ctl_status_t status,
    output ctl_cmd_t    cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LOOK = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (!status.out_blocked)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### hw/rtl/sact_datapath.sv
// ----------------------------------------------------------------------------
// sact_datapath: set memory, lookup, victim choice and result register
// Reads one set row, computes hit and replacement, writes the row back.
// ----------------------------------------------------------------------------
module sact_datapath
    import sact_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_wdata,
    input  logic                  kind,
    input  logic [ADDR_BITS-1:0]  address,
    input  ctl_cmd_t              cmd,
    output ctl_status_t           status,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic                  hit,
    output logic [WAY_BITS-1:0]   way,
    output logic                  filled,
    output logic                  writeback,
    output logic [LINE_BITS-1:0]  victim_line_address
);

    row_t                 mem [SETS];
    logic [SETS-1:0]      row_init_reg;
    row_t                 rd_row_reg;
    logic                 rd_init_reg;
    logic                 kind_reg;
    logic [LINE_BITS-1:0] line_reg;
    logic [1:0]           policy_reg;
    logic                 out_valid_reg;
    logic                 hit_reg;
    logic [WAY_BITS-1:0]  way_reg;
    logic                 wb_reg;
    logic [LINE_BITS-1:0] victim_reg;

    row_t                 cur;
    row_t                 upd;
    logic [SET_BITS-1:0]  set_idx;
    logic [SET_BITS-1:0]  in_set;
    logic [WAYS-1:0]      hit_vec;
    logic                 found;
    logic [WAY_BITS-1:0]  hit_way;
    logic                 free_any;
    logic [WAY_BITS-1:0]  free_way;
    logic                 clear_any;
    logic [WAY_BITS-1:0]  clear_way;
    logic [WAY_BITS-1:0]  tree_way;
    logic [WAY_BITS-1:0]  age_way;
    logic [WAY_BITS-1:0]  victim;
    logic [WAY_BITS-1:0]  touch_way;
    logic                 wb;

    assign in_set  = address[OFFSET_BITS +: SET_BITS];
    assign set_idx = line_reg[SET_BITS-1:0];

    always_comb
    begin
        cur = rd_row_reg;
        if (!rd_init_reg)
        begin
            cur.valid = '0;
            cur.dirty = '0;
            cur.mark  = '0;
            cur.age   = '0;
            cur.fifo  = '0;
            cur.tree  = '0;
        end
    end

    always_comb
    begin
        hit_vec   = '0;
        found     = 1'b0;
        hit_way   = '0;
        free_any  = 1'b0;
        free_way  = '0;
        clear_any = 1'b0;
        clear_way = '0;
        age_way   = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            hit_vec[i] = cur.valid[i] && (cur.tag[i] == line_reg);
        end
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                found   = 1'b1;
                hit_way = WAY_BITS'(i);
            end
            if (!cur.valid[i])
            begin
                free_any = 1'b1;
                free_way = WAY_BITS'(i);
            end
        end
        for (int i = 0; i < WAYS; i++)
        begin
            if (!cur.mark[i])
            begin
                clear_any = 1'b1;
                clear_way = WAY_BITS'(i);
            end
        end
        for (int i = 1; i < WAYS; i++)
        begin
            if (cur.age[i] > cur.age[age_way])
            begin
                age_way = WAY_BITS'(i);
            end
        end
        tree_way = {cur.tree[0], cur.tree[0] ? cur.tree[2] : cur.tree[1]};
    end

    always_comb
    begin
        upd = cur;
        wb  = 1'b0;
        victim = '0;
        if (found)
        begin
            touch_way = hit_way;
            if (kind_reg)
            begin
                upd.dirty[hit_way] = 1'b1;
            end
        end
        else
        begin
            priority if (policy_reg == POL_FIFO)
            begin
                victim   = cur.fifo;
                upd.fifo = cur.fifo + 1'b1;
            end
            else if (free_any)
            begin
                victim = free_way;
            end
            else if (policy_reg == POL_BITP)
            begin
                if (clear_any)
                begin
                    victim = clear_way;
                end
                else
                begin
                    victim   = '0;
                    upd.mark = '0;
                end
            end
            else if (policy_reg == POL_TREE)
            begin
                victim = tree_way;
            end
            else
            begin
                victim = age_way;
            end
            wb                = cur.valid[victim] && cur.dirty[victim];
            upd.tag[victim]   = line_reg;
            upd.valid[victim] = 1'b1;
            upd.dirty[victim] = kind_reg;
            touch_way         = victim;
        end
        if (touch_way[1])
        begin
            upd.tree[0] = 1'b0;
            upd.tree[2] = !touch_way[0];
        end
        else
        begin
            upd.tree[0] = 1'b1;
            upd.tree[1] = !touch_way[0];
        end
        for (int i = 0; i < WAYS; i++)
        begin
            if (WAY_BITS'(i) == touch_way)
            begin
                upd.age[i] = '0;
            end
            else if (upd.age[i] != '1)
            begin
                upd.age[i] = upd.age[i] + 1'b1;
            end
        end
        upd.mark[touch_way] = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rd_row_reg <= mem[in_set];
            kind_reg   <= kind;
            line_reg   <= address[ADDR_BITS-1:OFFSET_BITS];
        end
        if (cmd.commit)
        begin
            mem[set_idx] <= upd;
            hit_reg      <= found;
            way_reg      <= found ? hit_way : victim;
            wb_reg       <= wb;
            victim_reg   <= wb ? cur.tag[victim] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_init_reg  <= '0;
            rd_init_reg   <= 1'b0;
            policy_reg    <= POL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                policy_reg <= cfg_wdata;
            end
            if (cmd.capture)
            begin
                rd_init_reg <= row_init_reg[in_set];
            end
            if (cmd.commit)
            begin
                row_init_reg[set_idx] <= 1'b1;
                out_valid_reg         <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_blocked = out_valid_reg && !out_ready;
    assign out_valid           = out_valid_reg;
    assign hit                 = hit_reg;
    assign filled              = !hit_reg;
    assign way                 = way_reg;
    assign writeback           = wb_reg;
    assign victim_line_address = victim_reg;

endmodule

### hw/rtl/set_assoc_cache_tag_controller.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_controller: tag and replacement control of a cache
// Four-way, 64-set write-back cache tags with selectable replacement.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  in        in_valid, in_ready, kind, address         item in
//  out       out_valid, out_ready, hit, way, filled,   item out
//            writeback, victim_line_address
//  cfg       cfg_we, cfg_wdata                         policy write
//
// Each item first reads its set row from the set memory, then updates
// the row and loads the result register.
// A new item is taken while the previous result waits in the output register.
// The update stalls only while the result register is full and not taken.
// After reset all lines are invalid and the policy is tree PLRU.
module set_assoc_cache_tag_controller
    import sact_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 kind,
    input  logic [ADDR_BITS-1:0] address,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 hit,
    output logic [WAY_BITS-1:0]  way,
    output logic                 filled,
    output logic                 writeback,
    output logic [LINE_BITS-1:0] victim_line_address
);

    ctl_cmd_t    cmd;
    ctl_status_t status;

    sact_controller u_ctl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    sact_datapath u_dp
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_wdata           (cfg_wdata),
        .kind                (kind),
        .address             (address),
        .cmd                 (cmd),
        .status              (status),
        .out_ready           (out_ready),
        .out_valid           (out_valid),
        .hit                 (hit),
        .way                 (way),
        .filled              (filled),
        .writeback           (writeback),
        .victim_line_address (victim_line_address)
    );

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the cache tag controller
// Drives accesses under each replacement policy, predicts hit, way, fill and
// writeback from its own copy of the tag state, and compares every result.
// ----------------------------------------------------------------------------
class cache_scoreboard;
    typedef struct packed {
        logic                          hit;
        logic [sact_pkg::WAY_BITS-1:0] way;
        logic                          filled;
        logic                          writeback;
        logic [sact_pkg::LINE_BITS-1:0] victim;
    } access_result_t;

    logic [sact_pkg::LINE_BITS-1:0] tags   [sact_pkg::SETS][sact_pkg::WAYS];
    bit                             valid  [sact_pkg::SETS][sact_pkg::WAYS];
    bit                             dirty  [sact_pkg::SETS][sact_pkg::WAYS];
    bit                             marks  [sact_pkg::SETS][sact_pkg::WAYS];
    logic [7:0]                     ages   [sact_pkg::SETS][sact_pkg::WAYS];
    logic [1:0]                     fifo_ptr [sact_pkg::SETS];
    logic [2:0]                     tree   [sact_pkg::SETS];
    logic [1:0]                     policy;
    access_result_t                 pending[$];
    int                             mismatches;

    function new();
        foreach (valid[s, w])
        begin
            valid[s][w] = 0;
            dirty[s][w] = 0;
            marks[s][w] = 0;
            ages[s][w]  = 0;
            tags[s][w]  = '0;
        end
        foreach (fifo_ptr[s])
        begin
            fifo_ptr[s] = 0;
            tree[s]     = 0;
        end
        policy     = sact_pkg::POL_RESET;
        mismatches = 0;
    endfunction

    function void mark_used(int s, int w);
        if (w >= 2)
        begin
            tree[s][0] = 0;
            tree[s][2] = (w == 3) ? 1'b0 : 1'b1;
        end
        else
        begin
            tree[s][0] = 1;
            tree[s][1] = (w == 1) ? 1'b0 : 1'b1;
        end
        for (int i = 0; i < sact_pkg::WAYS; i++)
        begin
            if (i == w)
                ages[s][i] = 0;
            else if (ages[s][i] != 8'd255)
                ages[s][i]++;
        end
        marks[s][w] = 1;
    endfunction

    function void note_access(logic kind, logic [31:0] address);
        access_result_t r;
        logic [sact_pkg::LINE_BITS-1:0] line;
        int s;
        int w;
        bit found;
        bit chosen;
        bit any;
        line  = address[31:6];
        s     = line % sact_pkg::SETS;
        r     = '0;
        found = 0;
        w     = 0;
        for (int i = sact_pkg::WAYS - 1; i >= 0; i--)
            if (valid[s][i] && tags[s][i] == line)
            begin
                w     = i;
                found = 1;
            end
        if (found)
        begin
            if (kind)
                dirty[s][w] = 1;
        end
        else
        begin
            chosen = 0;
            if (policy == sact_pkg::POL_FIFO)
            begin
                w           = fifo_ptr[s];
                fifo_ptr[s] = fifo_ptr[s] + 2'd1;
                chosen      = 1;
            end
            for (int i = 0; i < sact_pkg::WAYS; i++)
                if (!chosen && !valid[s][i])
                begin
                    w      = i;
                    chosen = 1;
                end
            if (!chosen && policy == sact_pkg::POL_BITP)
            begin
                any = 0;
                for (int i = 0; i < sact_pkg::WAYS; i++)
                    if (!marks[s][i])
                    begin
                        w   = i;
                        any = 1;
                    end
                if (!any)
                begin
                    for (int i = 0; i < sact_pkg::WAYS; i++)
                        marks[s][i] = 0;
                    w = 0;
                end
            end
            else if (!chosen && policy == sact_pkg::POL_TREE)
            begin
                if (tree[s][0])
                    w = tree[s][2] ? 3 : 2;
                else
                    w = tree[s][1] ? 1 : 0;
            end
            else if (!chosen)
            begin
                w = 0;
                for (int i = 1; i < sact_pkg::WAYS; i++)
                    if (ages[s][i] > ages[s][w])
                        w = i;
            end
            if (valid[s][w] && dirty[s][w])
            begin
                r.writeback = 1;
                r.victim    = tags[s][w];
            end
            tags[s][w]  = line;
            valid[s][w] = 1;
            dirty[s][w] = kind;
        end
        mark_used(s, w);
        r.hit    = found;
        r.filled = !found;
        r.way    = sact_pkg::WAY_BITS'(w);
        pending.push_back(r);
    endfunction

    function void check_result(access_result_t got);
        access_result_t want;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected result %p", got);
            return;
        end
        want = pending.pop_front();
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Result differs: expected %p, got %p", want, got);
        end
    endfunction
endclass

module testbench;
    import sact_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [1:0]           cfg_wdata;
    logic                 in_valid;
    logic                 in_ready;
    logic                 kind;
    logic [ADDR_BITS-1:0] address;
    logic                 out_valid;
    logic                 out_ready;
    logic                 hit;
    logic [WAY_BITS-1:0]  way;
    logic                 filled;
    logic                 writeback;
    logic [LINE_BITS-1:0] victim_line_address;

    cache_scoreboard tags_model;
    int              idle_pct;
    int              stall_cycles;
    bit              timed_out;

    set_assoc_cache_tag_controller i_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_wdata           (cfg_wdata),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .kind                (kind),
        .address             (address),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .hit                 (hit),
        .way                 (way),
        .filled              (filled),
        .writeback           (writeback),
        .victim_line_address (victim_line_address)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tags_model.check_result({hit, way, filled, writeback, victim_line_address});
        if (rst_n)
            out_ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 5000 && !timed_out)
        begin
            timed_out = 1;
            $display("set_assoc_cache_tag_controller: mismatch");
            $finish;
        end
    end

    task automatic send_access(logic k, logic [31:0] a);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        kind     <= k;
        address  <= a;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tags_model.note_access(k, a);
    endtask

    task automatic set_policy(logic [1:0] p);
        in_valid <= 0;
        while (tags_model.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1;
        cfg_wdata <= p;
        @(posedge clk);
        cfg_we <= 0;
        tags_model.policy = p;
    endtask

    function automatic logic [31:0] pick_address(int pool_set, int pool_tags);
        logic [31:0] a;
        a        = $urandom;
        a[11:6]  = 6'($urandom_range(pool_set - 1));
        a[31:12] = (pool_tags == 0) ? a[31:12] : 20'($urandom_range(pool_tags - 1)) * 20'h9E37;
        return a;
    endfunction

    initial
    begin
        logic [1:0] order[6];
        tags_model = new();
        timed_out  = 0;
        idle_pct   = 25;
        rst_n      = 0;
        cfg_we     = 0;
        cfg_wdata  = POL_RESET;
        in_valid   = 0;
        kind       = 0;
        address    = '0;
        out_ready  = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;

        send_access(1'b1, 32'h0000_0000);
        send_access(1'b0, 32'hFFFF_FFFF);
        send_access(1'b1, 32'hFFFF_FFC0);
        send_access(1'b0, 32'h0000_003F);
        send_access(1'b1, 32'hAAAA_AAAA);
        send_access(1'b1, 32'h5555_5555);
        for (int t = 1; t <= 6; t++)
            send_access(1'b1, {20'(t), 6'd0, 6'($urandom)});
        send_access(1'b0, 32'h0000_1000);
        send_access(1'b1, 32'h0000_0000);
        set_policy(POL_FIFO);
        for (int t = 7; t <= 11; t++)
            send_access(t[0], {20'(t), 6'd0, 6'd0});
        set_policy(POL_BITP);
        for (int t = 12; t <= 16; t++)
            send_access(1'b1, {20'(t), 6'd0, 6'd0});
        set_policy(POL_AGE);
        for (int t = 17; t <= 20; t++)
            send_access(1'b0, {20'(t), 6'd0, 6'd0});

        order = '{POL_TREE, POL_FIFO, POL_BITP, POL_AGE, POL_TREE, POL_AGE};
        for (int ph = 0; ph < 6; ph++)
        begin
            set_policy(order[ph]);
            idle_pct = (ph == 2) ? 0 : 25;
            for (int n = 0; n < 300; n++)
            begin
                if ($urandom_range(9) == 0)
                    send_access(1'($urandom), $urandom);
                else
                    send_access(1'($urandom), pick_address(4, 7));
            end
        end

        in_valid <= 0;
        idle_pct = 25;
        while (tags_model.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (tags_model.mismatches == 0)
            $display("set_assoc_cache_tag_controller: match");
        else
            $display("set_assoc_cache_tag_controller: mismatch");
        $finish;
    end
endmodule
